### rtl/pqs_pkg.sv
// Package: shared codes and control types for the periodic query scheduler.
`timescale 1ns / 1ps

package pqs_pkg;

	// Field widths fixed by the word format
	localparam int unsigned ID_W   = 16;
	localparam int unsigned PER_W  = 16;
	localparam int unsigned TIME_W = 32;

	// Operation carried in the func field of a query word
	typedef enum logic {
		FUNC_REGISTER = 1'b0,
		FUNC_NEXT     = 1'b1
	} func_t;

	// Status code of a result word
	typedef enum logic [1:0] {
		STATUS_REGISTERED = 2'd0,
		STATUS_FULL       = 2'd1,
		STATUS_FIRED      = 2'd2,
		STATUS_EMPTY      = 2'd3
	} status_t;

	// Broadcast command from the controller to every cell of the row
	typedef struct packed {
		logic insert;   // place the broadcast key at its sorted position
		logic replace;  // drop the head and reinsert the broadcast key
	} cell_cmd_t;

endpackage

### rtl/pqs_query_if.sv
// Interface: query channel (valid, ready and the query word).
`timescale 1ns / 1ps

interface pqs_query_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] query_id;
	logic [15:0] period;

	modport source (output valid, output func, output query_id, output period, input ready);
	modport sink   (input valid, input func, input query_id, input period, output ready);
endinterface

### rtl/pqs_result_if.sv
// Interface: result channel (valid, ready and the result word).
`timescale 1ns / 1ps

interface pqs_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] fired_id;
	logic [31:0] fire_time;

	modport source (output valid, output status, output fired_id, output fire_time, input ready);
	modport sink   (input valid, input status, input fired_id, input fire_time, output ready);
endinterface

### rtl/pqs_cell.sv
// Cell: one entry of the sorted row, with its own key compare and neighbour hand-off.
`timescale 1ns / 1ps

module pqs_cell #(
	parameter int unsigned KEY_W = 49
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pqs_pkg::cell_cmd_t       cmd,
	input  logic [KEY_W-1:0]         bkey,
	input  logic [pqs_pkg::PER_W-1:0] bper,
	input  logic                     left_le,
	input  logic                     left_valid,
	input  logic [KEY_W-1:0]         left_key,
	input  logic [pqs_pkg::PER_W-1:0] left_per,
	input  logic                     right_le,
	input  logic [KEY_W-1:0]         right_key,
	input  logic [pqs_pkg::PER_W-1:0] right_per,
	output logic                     valid,
	output logic [KEY_W-1:0]         key,
	output logic [pqs_pkg::PER_W-1:0] per,
	output logic                     le
);

	logic                      valid_q;
	logic [KEY_W-1:0]          key_q;
	logic [pqs_pkg::PER_W-1:0] per_q;
	logic                      take_right;
	logic                      take_bcast;
	logic                      take_left;

	// Compare own key against the broadcast key
	assign le = valid_q && (key_q <= bkey);

	// Decide the move: shift left on replace, shift right on insert, or load the new key
	always_comb begin
		take_right = cmd.replace && right_le;
		take_bcast = (cmd.replace && le && !right_le) || (cmd.insert && !le && left_le);
		take_left  = cmd.insert && !le && !left_le;
	end

	// Occupancy: only an insert changes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.insert && !le) begin
			valid_q <= left_le ? 1'b1 : left_valid;
		end
	end

	// Payload: hold unless a move selects a new entry
	always_ff @(posedge clk) begin
		priority if (take_right) begin
			key_q <= right_key;
			per_q <= right_per;
		end else if (take_bcast) begin
			key_q <= bkey;
			per_q <= bper;
		end else if (take_left) begin
			key_q <= left_key;
			per_q <= left_per;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign per   = per_q;

endmodule

### rtl/periodic_query_scheduler_top.sv
// Top level: periodic query scheduler built on a sorted row of cells.
//
//   channel  dir  payload                              accepted when
//   query    in   func, query_id, period               query.valid && query.ready
//   result   out  status, fired_id, fire_time          result.valid && result.ready
//
// Accepting a word registers it with the broadcast key (for a next query, the head due
// time plus its period); the work state then lets every cell compare that key and
// move in one step. A new word is taken once the row has settled and the result
// register is free or draining. Reset empties the row at once; no clearing pass.
// A stalled result holds its register and blocks only the next query word.
`timescale 1ns / 1ps

module periodic_query_scheduler_top #(
	parameter int unsigned ENTRIES = 64
) (
	input logic         clk,
	input logic         arst_n,
	pqs_query_if.sink   query,
	pqs_result_if.source result
);

	localparam int unsigned SEQ_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
	localparam int unsigned KEY_W  = pqs_pkg::TIME_W + pqs_pkg::ID_W + SEQ_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t                      state_q;
	pqs_pkg::func_t              func_q;
	logic [KEY_W-1:0]            bkey_q;
	logic [pqs_pkg::PER_W-1:0]   bper_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        out_valid_q;
	pqs_pkg::status_t            out_status_q;
	logic [pqs_pkg::ID_W-1:0]    out_id_q;
	logic [pqs_pkg::TIME_W-1:0]  out_time_q;

	pqs_pkg::cell_cmd_t          cmd;
	logic                        accept;
	logic                        full;
	logic                        head_valid;
	logic [pqs_pkg::TIME_W-1:0]  head_due;
	logic [pqs_pkg::ID_W-1:0]    head_id;
	logic [SEQ_W-1:0]            head_seq;
	logic [pqs_pkg::TIME_W:0]    due_sum;
	logic [pqs_pkg::TIME_W-1:0]  due_next;

	// Row wiring with edge entries: index 0 is left of the first cell, ENTRIES+1 right of the last
	logic [ENTRIES:0]            valid_x;
	logic [ENTRIES+1:0]          le_x;
	logic [KEY_W-1:0]            key_x [ENTRIES+2];
	logic [pqs_pkg::PER_W-1:0]   per_x [ENTRIES+2];
	logic [ENTRIES-1:0]          valid_vec;

	assign valid_x[0]        = 1'b1;
	assign le_x[0]           = 1'b1;
	assign le_x[ENTRIES+1]   = 1'b0;
	assign key_x[0]          = '0;
	assign key_x[ENTRIES+1]  = '0;
	assign per_x[0]          = '0;
	assign per_x[ENTRIES+1]  = '0;
	assign valid_vec         = valid_x[ENTRIES:1];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		pqs_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.bkey       (bkey_q),
			.bper       (bper_q),
			.left_le    (le_x[i]),
			.left_valid (valid_x[i]),
			.left_key   (key_x[i]),
			.left_per   (per_x[i]),
			.right_le   (le_x[i+2]),
			.right_key  (key_x[i+2]),
			.right_per  (per_x[i+2]),
			.valid      (valid_x[i+1]),
			.key        (key_x[i+1]),
			.per        (per_x[i+1]),
			.le         (le_x[i+1])
		);
	end

	// Head of the row is the next due query
	assign head_valid = valid_x[1];
	assign head_due   = key_x[1][KEY_W-1 -: pqs_pkg::TIME_W];
	assign head_id    = key_x[1][SEQ_W +: pqs_pkg::ID_W];
	assign head_seq   = key_x[1][SEQ_W-1:0];
	assign full       = valid_x[ENTRIES];

	// Advance the head due time, saturating at the top
	assign due_sum  = {1'b0, head_due} +
		{{(pqs_pkg::TIME_W + 1 - pqs_pkg::PER_W){1'b0}}, per_x[1]};
	assign due_next = due_sum[pqs_pkg::TIME_W] ? '1 : due_sum[pqs_pkg::TIME_W-1:0];

	assign accept      = query.valid && query.ready;
	assign query.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);

	// Command the row during the work cycle
	always_comb begin
		cmd.insert  = (state_q == ST_WORK) && (func_q == pqs_pkg::FUNC_REGISTER) && !full;
		cmd.replace = (state_q == ST_WORK) && (func_q == pqs_pkg::FUNC_NEXT) && head_valid;
	end

	// Sequence: idle, then the work state for each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_WORK;
				ST_WORK: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the operation and the broadcast key on acceptance
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= pqs_pkg::func_t'(query.func);
			if (pqs_pkg::func_t'(query.func) == pqs_pkg::FUNC_REGISTER) begin
				bkey_q <= {{(pqs_pkg::TIME_W - pqs_pkg::PER_W){1'b0}}, query.period,
					query.query_id, cnt_q[SEQ_W-1:0]};
				bper_q <= query.period;
			end else begin
				bkey_q <= {due_next, head_id, head_seq};
				bper_q <= per_x[1];
			end
		end
	end

	// Count held queries; the count is also the insertion order of the next one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.insert) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Result register: load in the work cycle, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WORK) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WORK) begin
			unique case (func_q)
				pqs_pkg::FUNC_REGISTER: begin
					out_status_q <= full ? pqs_pkg::STATUS_FULL : pqs_pkg::STATUS_REGISTERED;
					out_id_q     <= '0;
					out_time_q   <= '0;
				end
				pqs_pkg::FUNC_NEXT: begin
					out_status_q <= head_valid ? pqs_pkg::STATUS_FIRED : pqs_pkg::STATUS_EMPTY;
					out_id_q     <= head_valid ? head_id : '0;
					out_time_q   <= head_valid ? head_due : '0;
				end
				default: begin
					out_status_q <= pqs_pkg::STATUS_EMPTY;
					out_id_q     <= '0;
					out_time_q   <= '0;
				end
			endcase
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.fired_id  = out_id_q;
	assign result.fire_time = out_time_q;

`ifndef ASSERT_OFF
	// Occupied cells always form a prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + (ENTRIES + 1)'(1)))
		else $error("occupied cells do not form a prefix");

	// Query count matches the occupied cells
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(valid_vec)))
		else $error("query count out of step with the row");

	// An accepted word is worked on in the next cycle
	a_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_WORK)
		else $error("accepted word not worked on");

	// Every work cycle leaves a result in the register
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WORK |=> out_valid_q)
		else $error("work cycle left no result");

	// The result register is free whenever a work cycle begins
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WORK |-> !out_valid_q)
		else $error("result overwritten before it was taken");
`endif

endmodule
